FILE: hdl/utgs_pkg.sv
// ----------------------------------------------------------------------------
// utgs_pkg: shared constants for the Unicode table glyph search
// Field widths, the glyph count limit and byte codes used by the decoder.
// ----------------------------------------------------------------------------
package utgs_pkg;

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 21;
    localparam int COUNT_W   = 16;
    localparam int PENDING_W = 2;

    // tdata packing on the slave side: table_byte, wanted_code, zero fill
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam int MAX_GLYPHS = 65536;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (MAX_GLYPHS - 1 > 65535) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_GLYPHS - 1);

    localparam logic [BYTE_W-1:0] BYTE_ENTRY_END = 8'hFF;

    localparam logic [5:0] CONT_MASK = 6'h3F;
    localparam logic [4:0] LEAD2_MASK = 5'h1F;
    localparam logic [3:0] LEAD3_MASK = 4'hF;
    localparam logic [2:0] LEAD4_MASK = 3'h7;

    localparam logic [PENDING_W-1:0] PEND_TWO_BYTE   = 2'd1;
    localparam logic [PENDING_W-1:0] PEND_THREE_BYTE = 2'd2;
    localparam logic [PENDING_W-1:0] PEND_FOUR_BYTE  = 2'd3;

endpackage

FILE: hdl/unicode_table_glyph_search.sv
// ----------------------------------------------------------------------------
// unicode_table_glyph_search: find the glyph that owns a wanted code point
// Scans a font Unicode table one byte per transaction and reports the match.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one table byte per transaction; tlast marks the last
//   byte of the table, and tdata also carries the wanted code point.
//   Master channel (m_*): at most one result per scan. tuser is set when the
//   code point was found and tdata holds the glyph index; a not-found result
//   is sent with the last table byte and carries index 0.
//   Config: cfg_wr_en/cfg_wr_data write unicode_enabled (reset 1); write it
//   only while no scan is in flight. With it cleared, bytes are ignored and
//   the table end gives not-found.
//   Output: the registered result appears in the cycle after its byte.
//   Throughput: one byte per cycle while s_tready is high; the byte decode,
//   code compare and count update are combinational ahead of scan state.
//   Stall: the result register holds while m_tready is low, and s_tready
//   drops only when that register is full and not being drained.
//   Reset: scan state clears, no result is pending, unicode_enabled is 1.
// ----------------------------------------------------------------------------
module unicode_table_glyph_search
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data, // unicode_enabled
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] table_byte, [28:8] wanted_code, [31:29] 0
    input  logic [utgs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,     // end_of_table
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [utgs_pkg::M_TDATA_W-1:0] m_tdata,     // [15:0] glyph_index
    output logic                           m_tuser      // [0] found
);

    logic                              enabled_reg;
    logic [utgs_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [utgs_pkg::CODE_W-1:0]       accum_reg, accum_next;
    logic [utgs_pkg::PENDING_W-1:0]    pending_reg, pending_next;
    logic                              done_reg, done_next;
    logic                              out_valid_reg;
    logic [utgs_pkg::COUNT_W-1:0]      out_index_reg;
    logic                              out_found_reg;

    logic [utgs_pkg::BYTE_W-1:0]       in_byte;
    logic [utgs_pkg::CODE_W-1:0]       in_want;
    logic                              accept;
    logic                              complete;
    logic [utgs_pkg::CODE_W-1:0]       code;
    logic                              match;
    logic                              emit;

    assign in_byte = s_tdata[7:0];
    assign in_want = s_tdata[28:8];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        count_next   = count_reg;
        accum_next   = accum_reg;
        pending_next = pending_reg;
        done_next    = done_reg;
        complete     = 1'b0;
        code         = '0;

        if (enabled_reg && !done_reg)
        begin
            priority if (pending_reg != '0)
            begin
                accum_next   = {accum_reg[utgs_pkg::CODE_W-7:0],
                                in_byte[5:0] & utgs_pkg::CONT_MASK};
                pending_next = pending_reg - 2'd1;
                complete     = (pending_reg == utgs_pkg::PEND_TWO_BYTE);
                code         = accum_next;
            end
            else if (in_byte == utgs_pkg::BYTE_ENTRY_END)
            begin
                if (count_reg < utgs_pkg::COUNT_LIMIT)
                    count_next = count_reg + 16'd1;
            end
            else if (in_byte[7])
            begin
                priority if (!in_byte[5])
                begin
                    accum_next   = utgs_pkg::CODE_W'(in_byte[4:0] & utgs_pkg::LEAD2_MASK);
                    pending_next = utgs_pkg::PEND_TWO_BYTE;
                end
                else if (!in_byte[4])
                begin
                    accum_next   = utgs_pkg::CODE_W'(in_byte[3:0] & utgs_pkg::LEAD3_MASK);
                    pending_next = utgs_pkg::PEND_THREE_BYTE;
                end
                else if (!in_byte[3])
                begin
                    accum_next   = utgs_pkg::CODE_W'(in_byte[2:0] & utgs_pkg::LEAD4_MASK);
                    pending_next = utgs_pkg::PEND_FOUR_BYTE;
                end
                else
                begin
                    // 0xB8..0xBF and 0xF8..0xFE stand for code 0 on their own
                    complete = 1'b1;
                    code     = '0;
                end
            end
            else
            begin
                complete = 1'b1;
                code     = utgs_pkg::CODE_W'(in_byte);
            end
        end

        match = complete && (code == in_want);
        if (match)
            done_next = 1'b1;

        emit = match || (s_tlast && !done_reg);

        // end of table: drop partial code and start the next scan clean
        if (s_tlast)
        begin
            count_next   = '0;
            accum_next   = '0;
            pending_next = '0;
            done_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            count_reg     <= '0;
            accum_reg     <= '0;
            pending_reg   <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                enabled_reg <= cfg_wr_data;

            if (accept)
            begin
                count_reg   <= count_next;
                accum_reg   <= accum_next;
                pending_reg <= pending_next;
                done_reg    <= done_next;
            end

            if (accept && emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_index_reg <= match ? count_reg : '0;
            out_found_reg <= match;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_index_reg;
    assign m_tuser  = out_found_reg;

endmodule

FILE: hdl/utgs_checker.sv
// ----------------------------------------------------------------------------
// utgs_checker: port-level checks for the Unicode table glyph search
// Watches both stream channels and flags results that break the contract.
// ----------------------------------------------------------------------------
module utgs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    logic held;
    logic s_fire;

    assign held   = m_tvalid && !m_tready;
    assign s_fire = s_tvalid && s_tready;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        held |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result with nonzero index");

    // a fresh result comes from the transaction in the cycle before
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !$past(held) |-> $past(s_fire))
        else $error("result without an accepted byte");

    a_nf_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && !$past(held) |-> $past(s_fire && s_tlast))
        else $error("not-found result away from table end");

    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        held |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

bind unicode_table_glyph_search utgs_checker u_utgs_checker (.*);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for unicode_table_glyph_search
// Streams Unicode table bytes through the slave channel and checks every
// lookup result against a cycle-free model of the decoder. The run covers
// directed tables, random well-formed, truncated and noise tables with random
// idling on both channels, and scans with Unicode disabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [15:0] glyph;
        logic        found;
    } lookup_t;

    // One table byte plus an optional typed-in lookup result
    typedef struct packed {
        logic [7:0]  tbyte;
        logic        last;
        logic [20:0] want;
        logic        typed;
        logic        has;
        logic [15:0] glyph;
        logic        found;
    } row_t;

    localparam int N_DIR = 25;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;           // [7:0] table_byte, [28:8] wanted_code, [31:29] 0
    logic        s_tlast;           // end_of_table
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;           // [15:0] glyph_index
    logic        m_tuser;           // [0] found

    // Decoder model state
    logic        unicode_on;
    logic [15:0] glyph_cnt;
    logic [20:0] partial_code;
    logic [1:0]  cont_left;
    logic        hit_seen;

    lookup_t     lookup_q [$];
    logic [7:0]  tbl_q [$];
    logic [20:0] code_q [$];
    row_t        cur_row;
    bit          no_idle;
    int          mismatches;
    int          bytes_in;
    int          results_out;
    int          hits_out;
    int          random_bytes;

    row_t dir_rows [0:N_DIR-1] = '{
        '{8'h41, 1'b0, 21'h41,     1'b1, 1'b1, 16'd0, 1'b1},  // plain byte hits glyph 0
        '{8'h42, 1'b0, 21'h41,     1'b1, 1'b0, 16'd0, 1'b0},  // ignored after the hit
        '{8'hFF, 1'b1, 21'h41,     1'b1, 1'b0, 16'd0, 1'b0},  // end after hit: nothing more
        '{8'h00, 1'b0, 21'h1FFFFF, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'hFF, 1'b0, 21'h1FFFFF, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'hF7, 1'b0, 21'h1FFFFF, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'hBF, 1'b0, 21'h1FFFFF, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'hBF, 1'b0, 21'h1FFFFF, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'hBF, 1'b1, 21'h1FFFFF, 1'b1, 1'b1, 16'd1, 1'b1},  // largest code, hit on last
        '{8'hFF, 1'b0, 21'h0,      1'b1, 1'b0, 16'd0, 1'b0},
        '{8'hFE, 1'b1, 21'h0,      1'b1, 1'b1, 16'd1, 1'b1},  // lone code-0 lead byte
        '{8'hC1, 1'b1, 21'h7F,     1'b1, 1'b1, 16'd0, 1'b0},  // form cut off by the end
        '{8'h7F, 1'b1, 21'h7F,     1'b1, 1'b1, 16'd0, 1'b1},
        '{8'hDF, 1'b0, 21'h7FF,    1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hBF, 1'b1, 21'h7FF,    1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hC0, 1'b0, 21'h3F,     1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hFF, 1'b1, 21'h3F,     1'b0, 1'b0, 16'd0, 1'b0},  // 0xFF as continuation
        '{8'hFF, 1'b0, 21'hFFFF,   1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hEF, 1'b0, 21'hFFFF,   1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hBF, 1'b0, 21'hFFFF,   1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hBF, 1'b0, 21'hFFFF,   1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h00, 1'b1, 21'hFFFF,   1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hB8, 1'b0, 21'h1,      1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h80, 1'b0, 21'h5,      1'b0, 1'b0, 16'd0, 1'b0},  // wanted code moves mid-scan
        '{8'h81, 1'b1, 21'h1,      1'b0, 1'b0, 16'd0, 1'b0}
    };

    unicode_table_glyph_search dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic decode_table_byte(input logic [7:0] b, input logic last,
                                     input logic [20:0] want, output logic has,
                                     output lookup_t res);
        logic        complete;
        logic [20:0] code;
        has      = 1'b0;
        res      = '0;
        complete = 1'b0;
        code     = '0;
        if (unicode_on && !hit_seen)
        begin
            if (cont_left != 0)
            begin
                partial_code = {partial_code[14:0], b[5:0]};
                cont_left    = cont_left - 2'd1;
                if (cont_left == 0)
                begin
                    complete = 1'b1;
                    code     = partial_code;
                end
            end
            else if (b == utgs_pkg::BYTE_ENTRY_END)
            begin
                if (glyph_cnt < utgs_pkg::COUNT_LIMIT)
                    glyph_cnt = glyph_cnt + 16'd1;
            end
            else if (b[7])
            begin
                if (!b[5])
                begin
                    partial_code = 21'(b[4:0]);
                    cont_left    = utgs_pkg::PEND_TWO_BYTE;
                end
                else if (!b[4])
                begin
                    partial_code = 21'(b[3:0]);
                    cont_left    = utgs_pkg::PEND_THREE_BYTE;
                end
                else if (!b[3])
                begin
                    partial_code = 21'(b[2:0]);
                    cont_left    = utgs_pkg::PEND_FOUR_BYTE;
                end
                else
                begin
                    complete = 1'b1;
                end
            end
            else
            begin
                complete = 1'b1;
                code     = 21'(b);
            end
            if (complete && code == want)
            begin
                has       = 1'b1;
                res.glyph = glyph_cnt;
                res.found = 1'b1;
                hit_seen  = 1'b1;
            end
        end
        if (last)
        begin
            if (!has && !hit_seen)
            begin
                has = 1'b1;
                res = '0;
            end
            glyph_cnt    = '0;
            partial_code = '0;
            cont_left    = '0;
            hit_seen     = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        logic    has;
        lookup_t res;
        lookup_t exp_res;
        if (rst_n && s_tvalid && s_tready)
        begin
            decode_table_byte(s_tdata[7:0], s_tlast, s_tdata[28:8], has, res);
            if (cur_row.typed)
            begin
                has       = cur_row.has;
                res.glyph = cur_row.glyph;
                res.found = cur_row.found;
            end
            if (has)
                lookup_q.push_back(res);
            bytes_in++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            results_out++;
            if (m_tuser === 1'b1)
                hits_out++;
            if (lookup_q.size() == 0)
            begin
                $display("%0t: unexpected result, glyph_index %0d found %0b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                exp_res = lookup_q.pop_front();
                if (m_tdata !== exp_res.glyph)
                begin
                    $display("%0t: glyph_index expected %0d actual %0d",
                             $time, exp_res.glyph, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== exp_res.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, exp_res.found, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Result channel back-pressure
    initial
    begin : sink
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0 && !no_idle)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    task automatic send_byte(input row_t r);
        int gap;
        @(negedge clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_row  = r;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.want, r.tbyte};
        s_tlast  <= r.last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (lookup_q.size() != 0)
            @(negedge clk);
        // a scan ending in a dropped byte may still be in flight
        repeat (3) @(negedge clk);
    endtask

    task automatic write_enable(input logic v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        unicode_on  = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Append one encoded code point; lead and continuation filler bits are random
    task automatic add_code();
        int          form;
        logic [20:0] c;
        logic [7:0]  lead;
        form = $urandom_range(0, 4);
        c    = 21'($urandom);
        case (form)
            0:
            begin
                c = c & 21'h7F;
                tbl_q.push_back(c[7:0]);
            end
            1:
            begin
                c = c & 21'h7FF;
                tbl_q.push_back({1'b1, 1'($urandom), 1'b0, c[10:6]});
                tbl_q.push_back({2'($urandom), c[5:0]});
            end
            2:
            begin
                c = c & 21'hFFFF;
                tbl_q.push_back({1'b1, 1'($urandom), 2'b10, c[15:12]});
                tbl_q.push_back({2'($urandom), c[11:6]});
                tbl_q.push_back({2'($urandom), c[5:0]});
            end
            3:
            begin
                tbl_q.push_back({1'b1, 1'($urandom), 3'b110, c[20:18]});
                tbl_q.push_back({2'($urandom), c[17:12]});
                tbl_q.push_back({2'($urandom), c[11:6]});
                tbl_q.push_back({2'($urandom), c[5:0]});
            end
            default:
            begin
                c    = '0;
                lead = {1'b1, 1'($urandom), 3'b111, 3'($urandom)};
                if (lead == utgs_pkg::BYTE_ENTRY_END)
                    lead = 8'hF8;
                tbl_q.push_back(lead);
            end
        endcase
        code_q.push_back(c);
    endtask

    function automatic logic [20:0] pick_want();
        if (code_q.size() > 0 && $urandom_range(0, 3) != 0)
            return code_q[$urandom_range(0, code_q.size() - 1)];
        else if ($urandom_range(0, 1) != 0)
            return 21'($urandom_range(0, 255));
        else
            return 21'($urandom);
    endfunction

    task automatic random_scan();
        int          kind;
        int          n;
        int          cut;
        int          sw;
        logic [20:0] want;
        logic [20:0] want2;
        row_t        r;
        tbl_q.delete();
        code_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 82)
        begin
            n = $urandom_range(1, 10);
            for (int g = 0; g < n; g++)
            begin
                repeat ($urandom_range(1, 3)) add_code();
                if (g < n - 1 || $urandom_range(0, 1) != 0)
                    tbl_q.push_back(utgs_pkg::BYTE_ENTRY_END);
            end
            // truncate, often in the middle of a multi-byte form
            if (kind >= 70)
            begin
                cut = $urandom_range(1, tbl_q.size());
                while (tbl_q.size() > cut)
                    void'(tbl_q.pop_back());
            end
        end
        else if (kind < 94)
        begin
            repeat ($urandom_range(1, 16)) tbl_q.push_back(8'($urandom));
        end
        else
        begin
            tbl_q.push_back(8'($urandom));
        end
        want  = pick_want();
        want2 = pick_want();
        sw    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, tbl_q.size() - 1)
                                             : tbl_q.size();
        no_idle = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < tbl_q.size(); i++)
        begin
            r       = '0;
            r.tbyte = tbl_q[i];
            r.last  = (i == tbl_q.size() - 1);
            r.want  = (i < sw) ? want : want2;
            send_byte(r);
        end
        no_idle = 1'b0;
        random_bytes += tbl_q.size();
    endtask

    initial
    begin : stimulus
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cur_row      = '0;
        no_idle      = 1'b0;
        mismatches   = 0;
        bytes_in     = 0;
        results_out  = 0;
        hits_out     = 0;
        random_bytes = 0;
        unicode_on   = 1'b1;
        glyph_cnt    = '0;
        partial_code = '0;
        cont_left    = '0;
        hit_seen     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_byte(dir_rows[i]);

        // disabled: every scan ends not-found
        write_enable(1'b0);
        repeat (8) random_scan();
        write_enable(1'b1);
        random_bytes = 0;
        while (random_bytes < 1400)
            random_scan();

        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (lookup_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Run covered %0d table bytes and %0d lookup results (%0d hits),",
                 bytes_in, results_out, hits_out);
        $display("with Unicode on and off, truncated and noisy tables, moving wanted codes.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("%0t: timeout, %0d lookups still pending", $time, lookup_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
